// ===== hdl/sniffed_mac_presence_table_macros.svh =====
// Assertion helpers for the presence table.
// Both expect clk and rst_n in scope.
`ifndef SNIFFED_MAC_PRESENCE_TABLE_MACROS_SVH
`define SNIFFED_MAC_PRESENCE_TABLE_MACROS_SVH

// Same-cycle implication.
`define SMPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smpt assertion failed");

// Next-cycle implication.
`define SMPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smpt assertion failed");

`endif

// ===== hdl/smpt_pkg.sv =====
`default_nettype none
package smpt_pkg;

  localparam int MAC_W    = 48;
  localparam int RSSI_W   = 8;
  localparam int TIMER_W  = 20;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int USER_REGS  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // presence events
  localparam logic [1:0] EVT_NONE     = 2'd0;
  localparam logic [1:0] EVT_DETECTED = 2'd1;
  localparam logic [1:0] EVT_ABSENT   = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SNIFF_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENCE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MAC_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MAC_B    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MAC_C    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MAC_D    = 3'd6;

  typedef struct packed {
    logic                              sniff_enable;
    logic [TIMER_W-1:0]                absence_ticks;
    logic [USER_REGS-1:0]              user_mask;
    logic [USER_REGS-1:0][MAC_W-1:0]   user_mac;
  } cfg_t;

  // parser view of the byte just taken
  typedef struct packed {
    logic              done;
    logic              good;
    logic [MAC_W-1:0]  mac;
    logic [RSSI_W-1:0] rssi;
  } frame_t;

  typedef struct packed {
    logic   go;
    logic   is_tick;
    frame_t frm;
  } start_t;

  // one table entry as stored in RAM
  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [RSSI_W-1:0]  rssi;
    logic [TIMER_W-1:0] timer;
    logic               is_user;
  } entry_t;

  typedef struct packed {
    logic              frame_good;
    logic              frame_bad;
    logic [MAC_W-1:0]  seen_mac;
    logic [RSSI_W-1:0] seen_rssi;
    logic              entry_added;
    logic              entry_dropped;
    logic [CNT_W-1:0]  user_count;
    logic [1:0]        presence_event;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/smpt_ram.sv =====
`default_nettype none
module smpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  wire logic             clk;
  input  wire logic             we;
  input  wire logic [AW-1:0]    waddr;
  input  wire logic [WIDTH-1:0] wdata;
  input  wire logic [AW-1:0]    raddr;
  output      logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/smpt_parser.sv =====
`default_nettype none
module smpt_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                byte_en,
  input  wire logic [7:0]          rx_byte,
  output      smpt_pkg::frame_t    frm
);
  import smpt_pkg::*;

  localparam logic [7:0] SYNC_BYTE    = 8'hFE;
  localparam logic [3:0] PH_SYNC_LAST = 4'd3;
  localparam logic [3:0] PH_MAC_FIRST = 4'd4;
  localparam logic [3:0] PH_MAC_LAST  = 4'd9;
  localparam logic [3:0] PH_RSSI      = 4'd10;
  localparam logic [3:0] PH_CSUM      = 4'd11;

  logic [3:0]        phase_r, phase_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [RSSI_W-1:0] rssi_r, rssi_nxt;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    mac_nxt   = mac_r;
    rssi_nxt  = rssi_r;
    frm.done  = 1'b0;
    frm.good  = (xor_r == rx_byte);
    frm.mac   = mac_r;
    frm.rssi  = rssi_r;
    if (byte_en) begin
      priority if (phase_r <= PH_SYNC_LAST) begin
        // a stray byte restarts the hunt and is not a first sync byte
        phase_nxt = (rx_byte == SYNC_BYTE) ? phase_r + 4'd1 : 4'd0;
      end else if (phase_r == PH_MAC_FIRST) begin
        mac_nxt   = MAC_W'(rx_byte);
        xor_nxt   = rx_byte;
        phase_nxt = phase_r + 4'd1;
      end else if (phase_r <= PH_MAC_LAST) begin
        mac_nxt   = {mac_r[MAC_W-9:0], rx_byte};
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = phase_r + 4'd1;
      end else if (phase_r == PH_RSSI) begin
        rssi_nxt  = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = phase_r + 4'd1;
      end else if (phase_r == PH_CSUM) begin
        frm.done  = 1'b1;
        phase_nxt = 4'd0;
      end else begin
        phase_nxt = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 4'd0;
      xor_r   <= 8'd0;
      mac_r   <= '0;
      rssi_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      mac_r   <= mac_nxt;
      rssi_r  <= rssi_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smpt_engine.sv =====
`default_nettype none
module smpt_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int USER_SLOTS  = 4
) (
  clk,
  rst_n,
  start,
  cfg,
  cfg_disable,
  idle,
  res_valid,
  res_take,
  res,
  ram_we,
  ram_waddr,
  ram_wdata,
  ram_raddr,
  ram_rdata
);
  import smpt_pkg::*;

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UCW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  input  wire logic                clk;
  input  wire logic                rst_n;
  input  wire smpt_pkg::start_t    start;
  input  wire smpt_pkg::cfg_t      cfg;
  input  wire logic                cfg_disable;
  output      logic                idle;
  output      logic                res_valid;
  input  wire logic                res_take;
  output      smpt_pkg::result_t   res;
  output      logic                ram_we;
  output      logic [IW-1:0]       ram_waddr;
  output      smpt_pkg::entry_t    ram_wdata;
  output      logic [IW-1:0]       ram_raddr;
  input  wire smpt_pkg::entry_t    ram_rdata;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LAST   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic                   tick_r, tick_nxt;
  frame_t                 frm_r, frm_nxt;
  logic                   hit_r, hit_nxt;
  logic                   free_r, free_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic                   added_r, added_nxt;
  logic                   dropped_r, dropped_nxt;
  logic [1:0]             evt_r, evt_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [UCW-1:0]         ucnt_r, ucnt_nxt;
  logic [CNT_W-1:0]       prev_r, prev_nxt;

  logic [UCW+CNT_W-1:0]   ucnt_ext;
  logic [CNT_W-1:0]       cnt_sat;
  logic                   user_hit;
  logic                   cur_vld;

  assign ucnt_ext = (UCW+CNT_W)'(ucnt_r);
  assign cnt_sat  = (ucnt_ext > (UCW+CNT_W)'(CNT_MAX)) ? CNT_MAX : ucnt_ext[CNT_W-1:0];
  assign cur_vld  = valid_r[chk_idx_r];

  always_comb begin
    user_hit = 1'b0;
    for (int u = 0; u < USER_SLOTS; u++) begin
      if (cfg.user_mask[u] && (cfg.user_mac[u] == frm_r.mac)) begin
        user_hit = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    tick_nxt     = tick_r;
    frm_nxt      = frm_r;
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    added_nxt    = added_r;
    dropped_nxt  = dropped_r;
    evt_nxt      = evt_r;
    valid_nxt    = valid_r;
    ucnt_nxt     = ucnt_r;
    prev_nxt     = prev_r;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_r;
    chk_vld_nxt  = (st_r == ST_SCAN);
    chk_idx_nxt  = idx_r;

    if (cfg_disable) begin
      prev_nxt = cnt_sat;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start.go) begin
          tick_nxt    = start.is_tick;
          frm_nxt     = start.is_tick ? '0 : start.frm;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          added_nxt   = 1'b0;
          dropped_nxt = 1'b0;
          evt_nxt     = EVT_NONE;
          idx_nxt     = '0;
          st_nxt      = (start.is_tick || (start.frm.done && start.frm.good)) ?
                        ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          st_nxt = ST_LAST;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_LAST: begin
        st_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (tick_r) begin
          if (cfg.sniff_enable) begin
            if ((cnt_sat == '0) && (prev_r != '0)) begin
              evt_nxt = EVT_ABSENT;
            end else if ((cnt_sat != '0) && (prev_r == '0)) begin
              evt_nxt = EVT_DETECTED;
            end
          end
          prev_nxt = cnt_sat;
        end else if (!hit_r) begin
          if (free_r) begin
            ram_we            = 1'b1;
            ram_waddr         = free_idx_r;
            ram_wdata.mac     = frm_r.mac;
            ram_wdata.rssi    = frm_r.rssi;
            ram_wdata.timer   = cfg.absence_ticks;
            ram_wdata.is_user = user_hit;
            valid_nxt[free_idx_r] = 1'b1;
            if (user_hit) begin
              ucnt_nxt = ucnt_r + UCW'(1);
            end
            added_nxt = 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // read data for chk_idx_r is back: age it or match it
    if (chk_vld_r) begin
      if (tick_r) begin
        if (cur_vld) begin
          if (ram_rdata.timer != '0) begin
            ram_we          = 1'b1;
            ram_wdata.timer = ram_rdata.timer - TIMER_W'(1);
          end else begin
            valid_nxt[chk_idx_r] = 1'b0;
            if (ram_rdata.is_user) begin
              ucnt_nxt = ucnt_r - UCW'(1);
            end
          end
        end
      end else begin
        if (cur_vld && (ram_rdata.mac == frm_r.mac) && !hit_r) begin
          hit_nxt         = 1'b1;
          ram_we          = 1'b1;
          ram_wdata.rssi  = frm_r.rssi;
          ram_wdata.timer = cfg.absence_ticks;
        end else if (!cur_vld && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = chk_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
      ucnt_r    <= '0;
      prev_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      chk_vld_r <= chk_vld_nxt;
      valid_r   <= valid_nxt;
      ucnt_r    <= ucnt_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    tick_r     <= tick_nxt;
    frm_r      <= frm_nxt;
    hit_r      <= hit_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    added_r    <= added_nxt;
    dropped_r  <= dropped_nxt;
    evt_r      <= evt_nxt;
  end

  assign idle      = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_DONE);

  always_comb begin
    res.frame_good     = frm_r.done && frm_r.good;
    res.frame_bad      = frm_r.done && !frm_r.good;
    res.seen_mac       = frm_r.done ? frm_r.mac : '0;
    res.seen_rssi      = frm_r.done ? frm_r.rssi : '0;
    res.entry_added    = added_r;
    res.entry_dropped  = dropped_r;
    res.user_count     = cnt_sat;
    res.presence_event = evt_r;
  end

endmodule
`default_nettype wire

// ===== hdl/sniffed_mac_presence_table.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_req_type, in_rx_byte
// out_      output     out_valid/out_ready  frame flags, MAC, RSSI, add/drop, count, event
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// A byte that does not close a frame, or closes it with a bad checksum, goes straight to the result state.
// For a good frame end or a tick the table RAM read port visits every entry once,
// then the last-read, commit and result states follow.
// Reset is synchronous; valid bits live in flip-flops, so there is no clearing pass.
// A new request is taken while the previous result still waits in the output register.
`default_nettype none
`include "sniffed_mac_presence_table_macros.svh"
module sniffed_mac_presence_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int USER_SLOTS  = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_req_type,
  input  wire logic [7:0]                       in_rx_byte,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic                             out_frame_good,
  output      logic                             out_frame_bad,
  output      logic [smpt_pkg::MAC_W-1:0]       out_seen_mac,
  output      logic [smpt_pkg::RSSI_W-1:0]      out_seen_rssi,
  output      logic                             out_entry_added,
  output      logic                             out_entry_dropped,
  output      logic [smpt_pkg::CNT_W-1:0]       out_user_count,
  output      logic [1:0]                       out_presence_event,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [smpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smpt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import smpt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t     cfg_r;
  logic     cfg_disable;

  logic     in_accept;
  frame_t   frm;
  start_t   start;

  logic     eng_idle;
  logic     res_valid;
  logic     res_take;
  result_t  res;

  result_t  out_r;
  logic     out_valid_r, out_valid_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // ---- configuration registers ----
  // Writing 0 to sniff_enable snapshots the user count so a later
  // re-enable does not fire a stale event.
  assign cfg_disable = cfg_we && (cfg_index == CFG_SNIFF_ENABLE) && !cfg_wdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sniff_enable  <= 1'b1;
      cfg_r.absence_ticks <= TIMER_W'(600);
      cfg_r.user_mask     <= '0;
      cfg_r.user_mac      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SNIFF_ENABLE:  cfg_r.sniff_enable  <= cfg_wdata[0];
        CFG_ABSENCE_TICKS: cfg_r.absence_ticks <= cfg_wdata[TIMER_W-1:0];
        CFG_USER_MASK:     cfg_r.user_mask     <= cfg_wdata[USER_REGS-1:0];
        CFG_USER_MAC_A:    cfg_r.user_mac[0]   <= cfg_wdata[MAC_W-1:0];
        CFG_USER_MAC_B:    cfg_r.user_mac[1]   <= cfg_wdata[MAC_W-1:0];
        CFG_USER_MAC_C:    cfg_r.user_mac[2]   <= cfg_wdata[MAC_W-1:0];
        CFG_USER_MAC_D:    cfg_r.user_mac[3]   <= cfg_wdata[MAC_W-1:0];
        default: ;  // index out of range: ignored
      endcase
    end
  end

  // ---- request intake ----
  // The engine takes a request only when idle; the parser state moves at
  // the same edge so its frame view lines up with the request.
  assign in_ready  = eng_idle;
  assign in_accept = in_valid && in_ready;

  smpt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_accept && (in_req_type == REQ_BYTE)),
    .rx_byte (in_rx_byte),
    .frm     (frm)
  );

  always_comb begin
    start.go      = in_accept;
    start.is_tick = (in_req_type == REQ_TICK);
    start.frm     = frm;
  end

  // ---- table scan engine and entry RAM ----
  smpt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .USER_SLOTS  (USER_SLOTS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cfg         (cfg_r),
    .cfg_disable (cfg_disable),
    .idle        (eng_idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  smpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- output register ----
  // Loads when empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_good     = out_r.frame_good;
  assign out_frame_bad      = out_r.frame_bad;
  assign out_seen_mac       = out_r.seen_mac;
  assign out_seen_rssi      = out_r.seen_rssi;
  assign out_entry_added    = out_r.entry_added;
  assign out_entry_dropped  = out_r.entry_dropped;
  assign out_user_count     = out_r.user_count;
  assign out_presence_event = out_r.presence_event;

  // ---- assertions ----
  `SMPT_ASSERT_NXT(a_busy_after_accept, in_accept, !in_ready)
  `SMPT_ASSERT_IMP(a_good_bad_excl, out_valid_r, !(out_r.frame_good && out_r.frame_bad))
  `SMPT_ASSERT_IMP(a_add_needs_good,
                   out_valid_r && (out_r.entry_added || out_r.entry_dropped),
                   out_r.frame_good && !(out_r.entry_added && out_r.entry_dropped))
  `SMPT_ASSERT_IMP(a_event_code, out_valid_r,
                   (out_r.presence_event == EVT_NONE) ||
                   (out_r.presence_event == EVT_DETECTED) ||
                   (out_r.presence_event == EVT_ABSENT))

endmodule
`default_nettype wire
